// ----- design/s16df_pkg.sv -----
// Package for the sum16 packet deframer: frame layout constants and verdict codes.
// No dependencies; imported by sum16_packet_deframer_unit.
`timescale 1ns / 1ps
`default_nettype none

package s16df_pkg;

    // Byte offsets within one frame
    localparam logic [6:0] POS_ADDR     = 7'd2;   // first address byte
    localparam logic [6:0] POS_TYPE     = 7'd6;   // type byte
    localparam logic [6:0] POS_PAYLOAD  = 7'd9;   // first payload byte

    // Frame bytes beyond the payload, and length-field bytes beyond the payload
    localparam logic [6:0] FRAME_EXTRA  = 7'd11;
    localparam logic [6:0] LEN_EXTRA    = 7'd2;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_LEN_ERR  = 2'd1,
        VERDICT_SUM_ERR  = 2'd2
    } verdict_t;

endpackage

`default_nettype wire

// ----- design/sum16_packet_deframer_unit.sv -----
// Top level of the sum16 packet deframer: parses a byte stream into payload bytes and a verdict.
// Depends on s16df_pkg for frame offsets and verdict codes.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------------------
//  in      | in_valid / in_ready  | rx_byte, first_byte, expected_len
//  out     | out_valid / out_ready| kind, payload_byte, payload_pos, pkt_header,
//          |                      | pkt_address, pkt_type, verdict
//
// One request per cycle: each accepted byte is parsed in the cycle it is taken, and the
// frame state plus a single output register are updated at that edge. A result appears
// on the output in the cycle after its byte is accepted. The output register lets the input
// keep flowing while a result waits; input stalls only when the output register is full
// and out_ready is low. Reset (rst_n low) clears the parse state and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module sum16_packet_deframer_unit
    import s16df_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        first_byte,
    input  wire logic [6:0]  expected_len,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [7:0]       payload_byte,
    output logic [5:0]       payload_pos,
    output logic [15:0]      pkt_header,
    output logic [31:0]      pkt_address,
    output logic [7:0]       pkt_type,
    output logic [1:0]       verdict
);

    localparam logic [6:0] MAX_P = 7'(MAX_PAYLOAD);

    // Frame parse state
    logic [6:0]  byte_pos_reg,    byte_pos_next;
    logic [6:0]  exp_payload_reg, exp_payload_next;
    logic [15:0] header_reg,      header_next;
    logic [31:0] addr_reg,        addr_next;
    logic [7:0]  type_reg,        type_next;
    logic [15:0] len_field_reg,   len_field_next;
    logic [15:0] run_sum_reg,     run_sum_next;
    logic [15:0] rx_sum_reg,      rx_sum_next;

    // Output register
    logic        out_valid_reg,   out_valid_next;
    logic        kind_reg;
    logic [7:0]  payload_byte_reg;
    logic [5:0]  payload_pos_reg;
    logic [15:0] pkt_header_reg;
    logic [31:0] pkt_address_reg;
    logic [7:0]  pkt_type_reg;
    verdict_t    verdict_reg;

    // Per-byte parse results
    logic        accept;
    logic        emit;
    logic        emit_kind;
    verdict_t    emit_verdict;
    logic [6:0]  pos;
    logic [6:0]  exp_eff;
    logic [6:0]  total;
    logic [6:0]  payload_end;
    logic [15:0] header_eff;
    logic [31:0] addr_eff;
    logic [7:0]  type_eff;
    logic [15:0] len_eff;
    logic [15:0] run_eff;
    logic [15:0] rx_eff;

    // Accept a new byte whenever the output register is empty or draining this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // A start flag drops the frame in progress and samples the new length
        if (first_byte)
        begin
            exp_eff    = (expected_len > MAX_P) ? MAX_P : expected_len;
            pos        = '0;
            header_eff = '0;
            addr_eff   = '0;
            type_eff   = '0;
            len_eff    = '0;
            run_eff    = '0;
            rx_eff     = '0;
        end
        else
        begin
            exp_eff    = exp_payload_reg;
            pos        = byte_pos_reg;
            header_eff = header_reg;
            addr_eff   = addr_reg;
            type_eff   = type_reg;
            len_eff    = len_field_reg;
            run_eff    = run_sum_reg;
            rx_eff     = rx_sum_reg;
        end

        total       = exp_eff + FRAME_EXTRA;
        payload_end = POS_PAYLOAD + exp_eff;

        header_next    = header_eff;
        addr_next      = addr_eff;
        type_next      = type_eff;
        len_field_next = len_eff;
        run_sum_next   = run_eff;
        rx_sum_next    = rx_eff;
        byte_pos_next  = pos;
        emit           = 1'b0;
        emit_kind      = 1'b0;
        emit_verdict   = VERDICT_OK;

        // Bytes past the end of the frame are dropped until the next start flag
        if (pos < total)
        begin
            if (pos < POS_ADDR)
                header_next = {header_eff[7:0], rx_byte};
            else if (pos < POS_TYPE)
                addr_next = {addr_eff[23:0], rx_byte};
            else if (pos == POS_TYPE)
                type_next = rx_byte;
            else if (pos < POS_PAYLOAD)
                len_field_next = {len_eff[7:0], rx_byte};
            else if (pos < payload_end)
                emit = 1'b1;
            else
                rx_sum_next = {rx_eff[7:0], rx_byte};

            // Checksum covers type, length and payload bytes
            if (pos >= POS_TYPE && pos < payload_end)
                run_sum_next = run_eff + {8'd0, rx_byte};

            // The last byte is always the low checksum byte
            if (pos == total - 7'd1)
            begin
                emit      = 1'b1;
                emit_kind = 1'b1;
                if (len_eff != {9'd0, exp_eff + LEN_EXTRA})
                    emit_verdict = VERDICT_LEN_ERR;
                else if (rx_sum_next != run_eff)
                    emit_verdict = VERDICT_SUM_ERR;
                else
                    emit_verdict = VERDICT_OK;
            end

            byte_pos_next = pos + 7'd1;
        end

        exp_payload_next = exp_eff;
    end

    always_comb
    begin
        if (accept && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Parse state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg    <= '0;
            exp_payload_reg <= '0;
            header_reg      <= '0;
            addr_reg        <= '0;
            type_reg        <= '0;
            len_field_reg   <= '0;
            run_sum_reg     <= '0;
            rx_sum_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                byte_pos_reg    <= byte_pos_next;
                exp_payload_reg <= exp_payload_next;
                header_reg      <= header_next;
                addr_reg        <= addr_next;
                type_reg        <= type_next;
                len_field_reg   <= len_field_next;
                run_sum_reg     <= run_sum_next;
                rx_sum_reg      <= rx_sum_next;
            end
        end
    end

    // Result payload: load only when a result is produced
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg         <= emit_kind;
            payload_byte_reg <= emit_kind ? 8'd0 : rx_byte;
            payload_pos_reg  <= emit_kind ? 6'd0 : 6'(pos - POS_PAYLOAD);
            pkt_header_reg   <= header_next;
            pkt_address_reg  <= addr_next;
            pkt_type_reg     <= type_next;
            verdict_reg      <= emit_verdict;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_byte_reg;
    assign payload_pos  = payload_pos_reg;
    assign pkt_header   = pkt_header_reg;
    assign pkt_address  = pkt_address_reg;
    assign pkt_type     = pkt_type_reg;
    assign verdict      = verdict_reg;

`ifndef SYNTHESIS
    // Position never runs past the end of the current frame
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= exp_payload_reg + FRAME_EXTRA)
        else $error("byte position beyond frame end");

    // Sampled length is always saturated
    a_exp_sat: assert property (@(posedge clk) disable iff (!rst_n)
        exp_payload_reg <= MAX_P)
        else $error("expected payload length not saturated");

    // Last byte of a frame always yields a verdict in the next cycle
    a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !first_byte
            && byte_pos_reg == exp_payload_reg + FRAME_EXTRA - 7'd1)
        |=> (out_valid && kind))
        else $error("missing end-of-frame verdict");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for sum16_packet_deframer_unit: sends framed byte streams and checks each result.
// Depends on s16df_pkg for frame offsets and verdict codes, and on sum16_packet_deframer_unit.
`timescale 1ns / 1ps

module tb
    import s16df_pkg::*;
();

    localparam int PAYLOAD_CAP = 64;
    localparam int ITEM_TARGET = 1600;
    localparam int CALM_TAIL   = 250;   // last requests of the run go without idling

    // Result kinds as they appear on the kind port
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Ways a generated frame departs from a clean one
    typedef enum int {
        FLAW_NONE,
        FLAW_LEN,
        FLAW_SUM,
        FLAW_BOTH,
        FLAW_CUT,
        FLAW_TAIL,
        FLAW_NO_START
    } frame_flaw_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        logic [5:0]  ppos;
        logic [15:0] header;
        logic [31:0] address;
        logic [7:0]  ptype;
        verdict_t    verdict;
    } deframe_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        first_byte;
    logic [6:0]  expected_len;

    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_pos;
    logic [15:0] pkt_header;
    logic [31:0] pkt_address;
    logic [7:0]  pkt_type;
    logic [1:0]  verdict;

    // Shadow copy of the parser state
    logic [6:0]  frame_pos;
    logic [6:0]  payload_size;
    logic [15:0] header_cap;
    logic [31:0] address_cap;
    logic [7:0]  type_cap;
    logic [15:0] len_cap;
    logic [15:0] running_sum;
    logic [15:0] received_sum;

    deframe_result_t frame_results_due[$];
    deframe_result_t due_result;

    int  mismatch_count = 0;
    int  bytes_sent     = 0;
    bit  calm           = 1'b0;   // set near the end: no idling on either side

    sum16_packet_deframer_unit #(
        .MAX_PAYLOAD (PAYLOAD_CAP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .first_byte   (first_byte),
        .expected_len (expected_len),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .payload_pos  (payload_pos),
        .pkt_header   (pkt_header),
        .pkt_address  (pkt_address),
        .pkt_type     (pkt_type),
        .verdict      (verdict)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame parser prediction
    // ------------------------------------------------------------------

    task automatic clear_frame_state();
        frame_pos    = '0;
        header_cap   = '0;
        address_cap  = '0;
        type_cap     = '0;
        len_cap      = '0;
        running_sum  = '0;
        received_sum = '0;
    endtask

    // Package the captures as they stand now into one expected result
    function automatic deframe_result_t frame_result(input logic k, input logic [7:0] pb,
                                                     input logic [5:0] pp, input verdict_t v);
        deframe_result_t r;
        r.kind    = k;
        r.pbyte   = pb;
        r.ppos    = pp;
        r.header  = header_cap;
        r.address = address_cap;
        r.ptype   = type_cap;
        r.verdict = v;
        return r;
    endfunction

    // Advance the shadow parser by one accepted byte and queue what it must produce
    task automatic track_frame_byte(input logic [7:0] b, input logic fb, input logic [6:0] el);
        logic [6:0] frame_len;
        logic [6:0] payload_end;
        verdict_t   v;
        if (fb)
        begin
            clear_frame_state();
            payload_size = (el > PAYLOAD_CAP) ? 7'(PAYLOAD_CAP) : el;
        end
        frame_len   = payload_size + FRAME_EXTRA;
        payload_end = POS_PAYLOAD + payload_size;
        // Past the checksum: drop bytes until the next start flag
        if (frame_pos < frame_len)
        begin
            if (frame_pos < POS_ADDR)
                header_cap = {header_cap[7:0], b};
            else if (frame_pos < POS_TYPE)
                address_cap = {address_cap[23:0], b};
            else if (frame_pos == POS_TYPE)
                type_cap = b;
            else if (frame_pos < POS_PAYLOAD)
                len_cap = {len_cap[7:0], b};
            else if (frame_pos < payload_end)
                frame_results_due.push_back(frame_result(KIND_PAYLOAD, b,
                                            6'(frame_pos - POS_PAYLOAD), VERDICT_OK));
            else
                received_sum = {received_sum[7:0], b};

            // Sum runs from the type byte through the last payload byte
            if (frame_pos >= POS_TYPE && frame_pos < payload_end)
                running_sum = running_sum + 16'(b);

            if (frame_pos == frame_len - 7'd1)
            begin
                // Length field is judged before the checksum
                if (len_cap != 16'(payload_size) + 16'(LEN_EXTRA))
                    v = VERDICT_LEN_ERR;
                else if (received_sum != running_sum)
                    v = VERDICT_SUM_ERR;
                else
                    v = VERDICT_OK;
                frame_results_due.push_back(frame_result(KIND_VERDICT, 8'h00, 6'd0, v));
            end
            frame_pos = frame_pos + 7'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results_due.size() == 0)
                report_mismatch($sformatf("unexpected result, kind %0d", kind));
            else
            begin
                due_result = frame_results_due.pop_front();
                check_field("kind", 32'(kind), 32'(due_result.kind));
                check_field("payload_byte", 32'(payload_byte), 32'(due_result.pbyte));
                check_field("payload_pos", 32'(payload_pos), 32'(due_result.ppos));
                check_field("pkt_header", 32'(pkt_header), 32'(due_result.header));
                check_field("pkt_address", pkt_address, due_result.address);
                check_field("pkt_type", 32'(pkt_type), 32'(due_result.ptype));
                check_field("verdict", 32'(verdict), 32'(due_result.verdict));
            end
        end
    end

    // Receiver: stall in random bursts, never once the run goes calm
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one request and hold it until taken; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fb, input logic [6:0] el);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        rx_byte      <= b;
        first_byte   <= fb;
        expected_len <= el;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_frame_byte(b, fb, el);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] fill_byte(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    // Build one frame of plen payload bytes, apply a flaw, and send it.
    // len_code is what goes out on expected_len with the first byte.
    task automatic send_frame(input int unsigned plen, input logic [6:0] len_code,
                              input frame_flaw_t flaw, input fill_t fill);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  b;
        logic [7:0]  ptype;
        logic [15:0] len_word;
        logic [15:0] sum;
        int unsigned cut;
        int unsigned i;
        frame_bytes = {};
        // Header and address are only captured, so any content will do
        for (i = 0; i < 6; i++)
            frame_bytes.push_back(fill_byte(fill));
        ptype = fill_byte(fill);
        frame_bytes.push_back(ptype);
        len_word = 16'(plen) + 16'(LEN_EXTRA);
        if (flaw == FLAW_LEN || flaw == FLAW_BOTH)
            len_word = len_word ^ 16'($urandom_range(1, 16'hFFFF));
        frame_bytes.push_back(len_word[15:8]);
        frame_bytes.push_back(len_word[7:0]);
        sum = 16'(ptype) + 16'(len_word[15:8]) + 16'(len_word[7:0]);
        for (i = 0; i < plen; i++)
        begin
            b = fill_byte(fill);
            frame_bytes.push_back(b);
            sum = sum + 16'(b);
        end
        if (flaw == FLAW_SUM || flaw == FLAW_BOTH)
            sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        frame_bytes.push_back(sum[15:8]);
        frame_bytes.push_back(sum[7:0]);

        // A cut frame is abandoned part way; the next start flag takes over
        cut = frame_bytes.size();
        if (flaw == FLAW_CUT)
            cut = $urandom_range(1, frame_bytes.size() - 1);
        for (i = 0; i < cut; i++)
        begin
            if (i == 0 && flaw != FLAW_NO_START)
                send_byte(frame_bytes[i], 1'b1, len_code);
            else
                send_byte(frame_bytes[i], 1'b0, 7'($urandom_range(0, 127)));
        end
        // Stray bytes after the checksum must be dropped
        if (flaw == FLAW_TAIL)
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom), 1'b0, 7'($urandom_range(0, 127)));
    endtask

    // Unframed bytes, an occasional start flag with random length among them
    task automatic send_noise(input int unsigned count);
        repeat (count)
            send_byte(8'($urandom), ($urandom_range(0, 7) == 0), 7'($urandom_range(0, 127)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the length is zero, so bytes without a start flag form a bare frame
    task automatic test_bytes_before_start();
        send_frame(0, 7'd0, FLAW_NO_START, FILL_RANDOM);
    endtask

    task automatic test_field_extremes();
        send_frame(1, 7'd1, FLAW_NONE, FILL_ZERO);
        send_frame(PAYLOAD_CAP, 7'(PAYLOAD_CAP), FLAW_NONE, FILL_ONES);
    endtask

    // Lengths above the cap parse as a full-size frame
    task automatic test_length_saturation();
        send_frame(PAYLOAD_CAP, 7'd127, FLAW_NONE, FILL_RANDOM);
        send_frame(PAYLOAD_CAP, 7'd65, FLAW_NONE, FILL_RANDOM);
    endtask

    task automatic test_zero_length();
        send_frame(0, 7'd0, FLAW_NONE, FILL_RANDOM);
    endtask

    // Length error wins when both the length and the checksum are wrong
    task automatic test_verdict_codes();
        send_frame(3, 7'd3, FLAW_LEN, FILL_RANDOM);
        send_frame(3, 7'd3, FLAW_SUM, FILL_RANDOM);
        send_frame(3, 7'd3, FLAW_BOTH, FILL_RANDOM);
    endtask

    task automatic test_restart_mid_frame();
        send_frame(4, 7'd4, FLAW_CUT, FILL_RANDOM);
        send_frame(2, 7'd2, FLAW_NONE, FILL_RANDOM);
    endtask

    task automatic test_trailing_bytes();
        send_frame(2, 7'd2, FLAW_TAIL, FILL_RANDOM);
        send_frame(1, 7'd1, FLAW_NONE, FILL_RANDOM);
    endtask

    task automatic test_drain_pause();
        send_frame(5, 7'd5, FLAW_NONE, FILL_RANDOM);
        wait_for_drain();
        send_frame(5, 7'd5, FLAW_NONE, FILL_RANDOM);
    endtask

    // Mostly well-formed frames with random content, the rest flawed frames and noise;
    // runs until the whole test sequence has sent about ITEM_TARGET requests
    task automatic test_random_traffic();
        int unsigned next_drain;
        int unsigned roll;
        int unsigned plen;
        logic [6:0]  len_code;
        frame_flaw_t flaw;
        next_drain  = bytes_sent + 500;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent > ITEM_TARGET - CALM_TAIL)
                calm = 1'b1;
            if (bytes_sent >= next_drain)
            begin
                wait_for_drain();
                next_drain = bytes_sent + 500;
            end
            roll = $urandom_range(0, 99);
            if (roll < 15)
                send_noise($urandom_range(1, 20));
            else
            begin
                // Keep most frames short; full-size ones only now and then
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    plen = PAYLOAD_CAP;
                else if (roll < 3)
                    plen = $urandom_range(9, PAYLOAD_CAP - 1);
                else
                    plen = $urandom_range(0, 8);
                len_code = 7'(plen);
                if (plen == PAYLOAD_CAP && $urandom_range(0, 1) == 1)
                    len_code = 7'($urandom_range(PAYLOAD_CAP + 1, 127));
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    flaw = FLAW_NONE;
                else if (roll < 68)
                    flaw = FLAW_LEN;
                else if (roll < 76)
                    flaw = FLAW_SUM;
                else if (roll < 80)
                    flaw = FLAW_BOTH;
                else if (roll < 90)
                    flaw = FLAW_CUT;
                else
                    flaw = FLAW_TAIL;
                send_frame(plen, len_code, flaw, FILL_RANDOM);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        first_byte   = 1'b0;
        expected_len = '0;
        clear_frame_state();
        payload_size = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_bytes_before_start();
        test_field_extremes();
        test_length_saturation();
        test_zero_length();
        test_verdict_codes();
        test_restart_mid_frame();
        test_trailing_bytes();
        test_drain_pause();
        test_random_traffic();

        // Drop valid, let outstanding results drain, then let the pipe idle before the final report
        in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/s16df_pkg.sv
design/sum16_packet_deframer_unit.sv
test/tb.sv
